[rtl/core/rdbd_pkg.sv]
// Shared types and constants for the recorder data block deframer.
// No dependencies; used by every module under rtl/core.
package rdbd_pkg;

   // Header layout and framing codes
   localparam logic [2:0] HDR_LEN_BYTE  = 3'd1;
   localparam logic [2:0] HDR_TYPE_BYTE = 3'd7;
   localparam logic [7:0] HDR_LEN_ADJ   = 8'd2;
   localparam logic [7:0] TYPE_NO_CONT  = 8'h03;
   localparam logic [7:0] FLAG_OK       = 8'h01;
   localparam logic [7:0] ID_END_REC    = 8'h00;
   localparam logic [7:0] ID_NEW_MIN    = 8'd35;
   localparam logic [1:0] WORD_LAST_BYTE = 2'd2;

   // Block end status codes
   localparam logic [1:0] STATUS_NORMAL   = 2'd0;
   localparam logic [1:0] STATUS_FLAG_ERR = 2'd1;
   localparam logic [1:0] STATUS_END_REC  = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_CONT,
      PH_GID,
      PH_GSIZE,
      PH_GFLAG,
      PH_GDATA,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  header_count;
      logic [7:0]  words_in_block;
      logic [7:0]  current_group;
      logic [7:0]  size_of_group;
      logic [7:0]  words_in_run;
      logic [1:0]  byte_of_word;
      logic [15:0] word_accumulator;
      logic [7:0]  carried_remainder;
   } state_type;

   typedef struct packed {
      logic        word_valid;
      logic [7:0]  group_id;
      logic [23:0] group_word;
      logic        group_end;
      logic        new_group;
      logic        block_done;
      logic [1:0]  status;
      logic [7:0]  remainder_out;
   } result_type;

endpackage

[rtl/core/rdbd_step.sv]
// Per-byte next-state and result logic of the deframer.
// Depends on rdbd_pkg.
module rdbd_step (
   input  rdbd_pkg::state_type  cur,
   input  logic [7:0]           data_byte,
   input  logic                 block_start,
   input  logic                 save_words,
   output rdbd_pkg::state_type  nxt,
   output rdbd_pkg::result_type res,
   output logic                 emit
);

   logic        run_done;
   logic        fb_en;
   logic [1:0]  fb_status;
   logic [7:0]  fb_rem;
   logic        word_full;
   logic [23:0] full_word;
   logic [7:0]  wib_base;
   logic [7:0]  run_len;

   assign word_full = (cur.byte_of_word >= rdbd_pkg::WORD_LAST_BYTE);
   assign full_word = {cur.word_accumulator, data_byte};

   always_comb begin
      nxt       = cur;
      res       = '0;
      run_done  = 1'b0;
      fb_en     = 1'b0;
      fb_status = rdbd_pkg::STATUS_NORMAL;
      fb_rem    = '0;
      wib_base  = (cur.header_count == rdbd_pkg::HDR_LEN_BYTE) ? data_byte
                                                                 : cur.words_in_block;
      run_len   = '0;

      if (block_start) begin
         nxt.phase        = rdbd_pkg::PH_HDR;
         nxt.header_count = 3'd1;
      end else begin
         unique case (cur.phase)
            rdbd_pkg::PH_IDLE: begin
               nxt.phase = rdbd_pkg::PH_IDLE;
            end
            rdbd_pkg::PH_HDR: begin
               nxt.words_in_block = wib_base;
               if (cur.header_count >= rdbd_pkg::HDR_TYPE_BYTE) begin
                  nxt.words_in_block = wib_base - rdbd_pkg::HDR_LEN_ADJ;
                  nxt.header_count   = '0;
                  if (data_byte != rdbd_pkg::TYPE_NO_CONT &&
                      cur.carried_remainder != 8'd0) begin
                     // continuation words of the cut-off group come first
                     nxt.words_in_run     = cur.carried_remainder;
                     nxt.byte_of_word     = '0;
                     nxt.word_accumulator = '0;
                     nxt.phase            = rdbd_pkg::PH_CONT;
                  end else begin
                     res.group_end = (data_byte != rdbd_pkg::TYPE_NO_CONT);
                     if (nxt.words_in_block == 8'd0) fb_en = 1'b1;
                     else nxt.phase = rdbd_pkg::PH_GID;
                  end
               end else begin
                  nxt.header_count = cur.header_count + 3'd1;
               end
            end
            rdbd_pkg::PH_CONT: begin
               if (word_full) begin
                  res.word_valid       = save_words;
                  res.group_word       = save_words ? full_word : '0;
                  nxt.byte_of_word     = '0;
                  nxt.word_accumulator = '0;
                  nxt.words_in_block   = cur.words_in_block - 8'd1;
                  nxt.words_in_run     = cur.words_in_run - 8'd1;
                  if (nxt.words_in_run == 8'd0) begin
                     res.group_end = 1'b1;
                     if (nxt.words_in_block == 8'd0) fb_en = 1'b1;
                     else nxt.phase = rdbd_pkg::PH_GID;
                  end
               end else begin
                  nxt.word_accumulator = {cur.word_accumulator[7:0], data_byte};
                  nxt.byte_of_word     = cur.byte_of_word + 2'd1;
               end
            end
            rdbd_pkg::PH_GID: begin
               nxt.current_group = data_byte;
               nxt.phase         = rdbd_pkg::PH_GSIZE;
            end
            rdbd_pkg::PH_GSIZE: begin
               nxt.size_of_group = data_byte;
               nxt.phase         = rdbd_pkg::PH_GFLAG;
            end
            rdbd_pkg::PH_GFLAG: begin
               // the flag byte takes one word of block length
               nxt.words_in_block = cur.words_in_block - 8'd1;
               if (cur.current_group == rdbd_pkg::ID_END_REC) begin
                  if (nxt.words_in_block == 8'd0) begin
                     fb_en     = 1'b1;
                     fb_status = rdbd_pkg::STATUS_END_REC;
                  end else begin
                     nxt.words_in_run     = nxt.words_in_block;
                     nxt.byte_of_word     = '0;
                     nxt.word_accumulator = '0;
                     nxt.phase            = rdbd_pkg::PH_SKIP;
                  end
               end else if (data_byte != rdbd_pkg::FLAG_OK) begin
                  fb_en     = 1'b1;
                  fb_status = rdbd_pkg::STATUS_FLAG_ERR;
               end else begin
                  res.new_group = (cur.current_group > rdbd_pkg::ID_NEW_MIN);
                  run_len = (cur.size_of_group <= nxt.words_in_block) ? cur.size_of_group
                                                                      : nxt.words_in_block;
                  if (run_len == 8'd0) begin
                     run_done = 1'b1;
                  end else begin
                     nxt.words_in_run     = run_len;
                     nxt.byte_of_word     = '0;
                     nxt.word_accumulator = '0;
                     nxt.phase            = rdbd_pkg::PH_GDATA;
                  end
               end
            end
            rdbd_pkg::PH_GDATA: begin
               if (word_full) begin
                  res.word_valid       = save_words;
                  res.group_word       = save_words ? full_word : '0;
                  nxt.byte_of_word     = '0;
                  nxt.word_accumulator = '0;
                  nxt.words_in_run     = cur.words_in_run - 8'd1;
                  run_done             = (nxt.words_in_run == 8'd0);
               end else begin
                  nxt.word_accumulator = {cur.word_accumulator[7:0], data_byte};
                  nxt.byte_of_word     = cur.byte_of_word + 2'd1;
               end
            end
            rdbd_pkg::PH_SKIP: begin
               // drop the rest of the block after end of recording
               if (word_full) begin
                  nxt.byte_of_word     = '0;
                  nxt.word_accumulator = '0;
                  nxt.words_in_run     = cur.words_in_run - 8'd1;
                  if (nxt.words_in_run == 8'd0) begin
                     fb_en     = 1'b1;
                     fb_status = rdbd_pkg::STATUS_END_REC;
                  end
               end else begin
                  nxt.word_accumulator = {cur.word_accumulator[7:0], data_byte};
                  nxt.byte_of_word     = cur.byte_of_word + 2'd1;
               end
            end
         endcase
      end

      // group run complete: close the group or carry the rest to the next block
      if (run_done) begin
         if (nxt.size_of_group == nxt.words_in_block) begin
            res.group_end = 1'b1;
            fb_en         = 1'b1;
         end else if (nxt.size_of_group < nxt.words_in_block) begin
            res.group_end      = 1'b1;
            nxt.words_in_block = nxt.words_in_block - nxt.size_of_group;
            nxt.phase          = rdbd_pkg::PH_GID;
         end else begin
            fb_en  = 1'b1;
            fb_rem = nxt.size_of_group - nxt.words_in_block;
         end
      end

      if (fb_en) begin
         res.block_done        = 1'b1;
         res.status            = fb_status;
         res.remainder_out     = (fb_status == rdbd_pkg::STATUS_NORMAL) ? fb_rem : '0;
         nxt.carried_remainder = res.remainder_out;
         nxt.phase             = rdbd_pkg::PH_IDLE;
      end

      res.group_id = nxt.current_group;
   end

   assign emit = res.word_valid | res.group_end | res.new_group | res.block_done;

endmodule

[rtl/core/rdbd_rsp_fifo.sv]
// Two-entry result queue between the step logic and the rsp channel.
// Depends on rdbd_pkg.
module rdbd_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rdbd_pkg::result_type push_data,
   output logic                 has_space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rdbd_pkg::result_type out_data
);

   rdbd_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = out_valid & out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign has_space = (count_ff != 2'd2);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/recorder_data_block_deframer.sv]
// Recorder data block deframer: takes one byte per req transfer and emits group
// words and block markers. One byte is handled per cycle: a byte sits in the
// input register while the state update and result are formed, and results
// go through a two-entry queue, so the req side keeps taking a byte every
// cycle unless that queue is full because rsp is stalled. A result passes
// from the input register through that queue to rsp. Bytes that
// cause no result produce no rsp transfer. Configuration (save_words) is taken
// on any csr transfer and should only change while no bytes are in flight.
module recorder_data_block_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_block_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_word_valid,
   output logic [7:0]  rsp_group_id,
   output logic [23:0] rsp_group_word,
   output logic        rsp_group_end,
   output logic        rsp_new_group,
   output logic        rsp_block_done,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_remainder_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_save_words
);

   logic                 save_words_ff;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_start_ff;
   rdbd_pkg::state_type  state_ff, state_in;
   rdbd_pkg::result_type step_res, out_res;
   logic                 step_emit;
   logic                 fifo_space;
   logic                 byte_go;

   assign csr_ready = 1'b1;
   assign byte_go   = in_valid_ff & fifo_space;
   assign req_ready = ~in_valid_ff | byte_go;

   always_comb begin
      in_valid_in = req_valid & req_ready ? 1'b1 : (byte_go ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         save_words_ff <= 1'b1;
         in_valid_ff   <= 1'b0;
         state_ff      <= '0;
      end else begin
         if (csr_valid & csr_ready) save_words_ff <= csr_save_words;
         in_valid_ff <= in_valid_in;
         if (byte_go) state_ff <= state_in;
      end
   end

   // hold the byte until the step logic consumes it
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_block_start;
      end
   end

   rdbd_step u_step (
      .cur         (state_ff),
      .data_byte   (in_byte_ff),
      .block_start (in_start_ff),
      .save_words  (save_words_ff),
      .nxt         (state_in),
      .res         (step_res),
      .emit        (step_emit)
   );

   rdbd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_go & step_emit),
      .push_data (step_res),
      .has_space (fifo_space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_res)
   );

   assign rsp_word_valid    = out_res.word_valid;
   assign rsp_group_id      = out_res.group_id;
   assign rsp_group_word    = out_res.group_word;
   assign rsp_group_end     = out_res.group_end;
   assign rsp_new_group     = out_res.new_group;
   assign rsp_block_done    = out_res.block_done;
   assign rsp_status        = out_res.status;
   assign rsp_remainder_out = out_res.remainder_out;

   a_word_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_group_word != 24'd0 |-> rsp_word_valid)
      else $error("group word set without word_valid");

   a_rem_only_normal_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_remainder_out != 8'd0 |->
         rsp_block_done && rsp_status == rdbd_pkg::STATUS_NORMAL)
      else $error("remainder outside a normal block end");

   a_status_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rdbd_pkg::STATUS_NORMAL |-> rsp_block_done)
      else $error("status set without block_done");

   a_stalled_byte_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fifo_space |=> in_valid_ff && $stable(in_byte_ff)
         && $stable(state_ff))
      else $error("byte or state changed while result queue full");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for recorder_data_block_deframer: random data blocks with
// directed corner blocks, a byte-level predictor and per-field result checks.
// Depends on rdbd_pkg and the deframer RTL only.
module testbench;

   localparam int SETTLE_CYCLES  = 10;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [7:0] value;
      logic       first;
      logic       hold_for_drain;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_block_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_word_valid;
   logic [7:0]  rsp_group_id;
   logic [23:0] rsp_group_word;
   logic        rsp_group_end;
   logic        rsp_new_group;
   logic        rsp_block_done;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_remainder_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_save_words = 1'b0;

   byte_item_type        byte_stream[$];
   byte_item_type        draft_q[$];
   rdbd_pkg::result_type deframed_q[$];

   int   bytes_queued = 0;
   int   bytes_taken = 0;
   int   results_owed = 0;
   int   items_made = 0;
   int   gen_carry = 0;
   int   fail_count = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   logic throttle = 1'b0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   logic drain_next = 1'b0;

   // Predictor state
   rdbd_pkg::phase_type ph;
   logic [2:0]  hdr_idx;
   logic [7:0]  blk_words, grp, grp_size, run_left, carry_words;
   logic [1:0]  word_pos;
   logic [15:0] word_acc;
   logic        save_on;

   recorder_data_block_deframer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_block_start   (req_block_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_word_valid    (rsp_word_valid),
      .rsp_group_id      (rsp_group_id),
      .rsp_group_word    (rsp_group_word),
      .rsp_group_end     (rsp_group_end),
      .rsp_new_group     (rsp_new_group),
      .rsp_block_done    (rsp_block_done),
      .rsp_status        (rsp_status),
      .rsp_remainder_out (rsp_remainder_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_save_words    (csr_save_words)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void close_block(inout rdbd_pkg::result_type r,
                                       input logic [1:0] st, input logic [7:0] rem);
      r.block_done = 1'b1;
      r.status = st;
      r.remainder_out = (st == rdbd_pkg::STATUS_NORMAL) ? rem : 8'd0;
      carry_words = r.remainder_out;
      ph = rdbd_pkg::PH_IDLE;
   endfunction

   function automatic void open_groups(inout rdbd_pkg::result_type r);
      if (blk_words == 8'd0) close_block(r, rdbd_pkg::STATUS_NORMAL, 8'd0);
      else ph = rdbd_pkg::PH_GID;
   endfunction

   function automatic void close_run(inout rdbd_pkg::result_type r);
      if (grp_size == blk_words) begin
         r.group_end = 1'b1;
         close_block(r, rdbd_pkg::STATUS_NORMAL, 8'd0);
      end else if (grp_size < blk_words) begin
         r.group_end = 1'b1;
         blk_words = blk_words - grp_size;
         ph = rdbd_pkg::PH_GID;
      end else begin
         close_block(r, rdbd_pkg::STATUS_NORMAL, grp_size - blk_words);
      end
   endfunction

   function automatic void load_run(input logic [7:0] n);
      run_left = n;
      word_pos = 2'd0;
      word_acc = 16'd0;
   endfunction

   // Collect one byte; return 1 with the word in w once three have arrived.
   function automatic logic shift_in(input logic [7:0] b, output logic [23:0] w);
      w = 24'd0;
      if (word_pos >= rdbd_pkg::WORD_LAST_BYTE) begin
         w = {word_acc, b};
         word_pos = 2'd0;
         word_acc = 16'd0;
         return 1'b1;
      end
      word_acc = {word_acc[7:0], b};
      word_pos = word_pos + 2'd1;
      return 1'b0;
   endfunction

   function automatic logic deframe_byte(input logic [7:0] b, input logic first,
                                         output rdbd_pkg::result_type r);
      logic [23:0] w;
      logic [7:0]  n;
      r = '0;
      w = 24'd0;
      if (first) begin
         ph = rdbd_pkg::PH_HDR;
         hdr_idx = 3'd1;
         return 1'b0;
      end
      case (ph)
         rdbd_pkg::PH_HDR: begin
            if (hdr_idx == rdbd_pkg::HDR_LEN_BYTE) blk_words = b;
            if (hdr_idx >= rdbd_pkg::HDR_TYPE_BYTE) begin
               blk_words = blk_words - rdbd_pkg::HDR_LEN_ADJ;
               hdr_idx = 3'd0;
               if (b != rdbd_pkg::TYPE_NO_CONT) begin
                  if (carry_words != 8'd0) begin
                     load_run(carry_words);
                     ph = rdbd_pkg::PH_CONT;
                  end else begin
                     r.group_end = 1'b1;
                     open_groups(r);
                  end
               end else begin
                  open_groups(r);
               end
            end else begin
               hdr_idx = hdr_idx + 3'd1;
            end
         end
         rdbd_pkg::PH_CONT: begin
            if (shift_in(b, w)) begin
               if (save_on) begin
                  r.word_valid = 1'b1;
                  r.group_word = w;
               end
               blk_words = blk_words - 8'd1;
               run_left = run_left - 8'd1;
               if (run_left == 8'd0) begin
                  r.group_end = 1'b1;
                  open_groups(r);
               end
            end
         end
         rdbd_pkg::PH_GID: begin
            grp = b;
            ph = rdbd_pkg::PH_GSIZE;
         end
         rdbd_pkg::PH_GSIZE: begin
            grp_size = b;
            ph = rdbd_pkg::PH_GFLAG;
         end
         rdbd_pkg::PH_GFLAG: begin
            // the flag byte takes one word of the block length
            blk_words = blk_words - 8'd1;
            if (grp == rdbd_pkg::ID_END_REC) begin
               if (blk_words == 8'd0) close_block(r, rdbd_pkg::STATUS_END_REC, 8'd0);
               else begin
                  load_run(blk_words);
                  ph = rdbd_pkg::PH_SKIP;
               end
            end else if (b != rdbd_pkg::FLAG_OK) begin
               close_block(r, rdbd_pkg::STATUS_FLAG_ERR, 8'd0);
            end else begin
               if (grp > rdbd_pkg::ID_NEW_MIN) r.new_group = 1'b1;
               n = (grp_size <= blk_words) ? grp_size : blk_words;
               if (n == 8'd0) close_run(r);
               else begin
                  load_run(n);
                  ph = rdbd_pkg::PH_GDATA;
               end
            end
         end
         rdbd_pkg::PH_GDATA: begin
            if (shift_in(b, w)) begin
               if (save_on) begin
                  r.word_valid = 1'b1;
                  r.group_word = w;
               end
               run_left = run_left - 8'd1;
               if (run_left == 8'd0) close_run(r);
            end
         end
         rdbd_pkg::PH_SKIP: begin
            if (shift_in(b, w)) begin
               run_left = run_left - 8'd1;
               if (run_left == 8'd0) close_block(r, rdbd_pkg::STATUS_END_REC, 8'd0);
            end
         end
         default: ph = rdbd_pkg::PH_IDLE;
      endcase
      r.group_id = grp;
      return r.word_valid | r.group_end | r.new_group | r.block_done;
   endfunction

   // ---------------------------------------------------------------- driver and monitor

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic void compare_field(input string name, input logic [23:0] want,
                                         input logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : drive_req
      byte_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (byte_stream.size() > 0 &&
                      !(byte_stream[0].hold_for_drain && (req_valid || results_owed != 0))) begin
            nxt = byte_stream.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nxt.value;
            req_block_start <= nxt.first;
            send_gap <= throttle ? idle_len() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, armed once from the stimulus
   always @(posedge clock) begin : rsp_hold
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : watch_rsp
      rdbd_pkg::result_type fresh;
      rdbd_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         bytes_taken <= 0;
         results_owed <= 0;
         deframed_q.delete();
         save_on = 1'b1;
         ph = rdbd_pkg::PH_IDLE;
         hdr_idx = 3'd0;
         blk_words = 8'd0;
         grp = 8'd0;
         grp_size = 8'd0;
         run_left = 8'd0;
         word_pos = 2'd0;
         word_acc = 16'd0;
         carry_words = 8'd0;
      end else begin
         if (csr_valid && csr_ready) save_on = csr_save_words;
         if (req_valid && req_ready) begin
            if (deframe_byte(req_data_byte, req_block_start, fresh))
               deframed_q.push_back(fresh);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               $error("unexpected result transfer, group_id 0x%0h", rsp_group_id);
               fail_count++;
            end else begin
               want = deframed_q.pop_front();
               compare_field("word_valid", 24'(want.word_valid), 24'(rsp_word_valid));
               compare_field("group_id", 24'(want.group_id), 24'(rsp_group_id));
               compare_field("group_word", want.group_word, rsp_group_word);
               compare_field("group_end", 24'(want.group_end), 24'(rsp_group_end));
               compare_field("new_group", 24'(want.new_group), 24'(rsp_new_group));
               compare_field("block_done", 24'(want.block_done), 24'(rsp_block_done));
               compare_field("status", 24'(want.status), 24'(rsp_status));
               compare_field("remainder_out", 24'(want.remainder_out),
                             24'(rsp_remainder_out));
            end
         end
         results_owed <= deframed_q.size();
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp_ready <= 1'b1;
            stall_left <= throttle ? idle_len() : 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("recorder_data_block_deframer verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void draft(input logic [7:0] v, input logic first);
      byte_item_type it;
      it.value = v;
      it.first = first;
      it.hold_for_drain = drain_next;
      drain_next = 1'b0;
      draft_q.push_back(it);
   endfunction

   function automatic void draft_words(input int n);
      repeat (3 * n) draft(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   function automatic void draft_header(input logic [7:0] len, input logic [7:0] typ);
      draft(8'($urandom_range(0, 255)), 1'b1);
      draft(len, 1'b0);
      repeat (5) draft(8'($urandom_range(0, 255)), 1'b0);
      draft(typ, 1'b0);
   endfunction

   function automatic void commit(input int n);
      int i;
      for (i = 0; i < n; i++) byte_stream.push_back(draft_q[i]);
      bytes_queued += n;
      draft_q.delete();
   endfunction

   // Build one mostly well-formed block; now and then cut it short so the next
   // block start abandons it.
   task automatic random_block();
      int words, left, sz, keep, r, next_carry;
      logic [7:0] typ, id, flag;
      logic cont;
      draft_q.delete();
      typ = ($urandom_range(0, 2) == 0) ? rdbd_pkg::TYPE_NO_CONT
                                        : 8'($urandom_range(0, 255));
      cont = (typ != rdbd_pkg::TYPE_NO_CONT) && (gen_carry != 0);
      if ($urandom_range(0, 19) == 0) words = $urandom_range(0, 255);
      else words = (cont ? gen_carry : 0) + $urandom_range(0, 10);
      draft_header(8'(words) + rdbd_pkg::HDR_LEN_ADJ, typ);
      left = words & 255;
      next_carry = 0;
      if (cont) begin
         draft_words(gen_carry);
         left = (left - gen_carry) & 255;
      end
      while (left != 0) begin
         r = $urandom_range(0, 99);
         if (r < 4) id = rdbd_pkg::ID_END_REC;
         else if (r < 50) id = 8'($urandom_range(1, 35));
         else id = 8'($urandom_range(36, 255));
         r = $urandom_range(0, 99);
         if (r < 2) sz = $urandom_range(41, 255);
         else if (r < 12) sz = $urandom_range(7, 40);
         else sz = $urandom_range(0, 6);
         flag = rdbd_pkg::FLAG_OK;
         if ($urandom_range(0, 24) == 0) begin
            flag = 8'($urandom_range(0, 255));
            if (flag == rdbd_pkg::FLAG_OK) flag = 8'hFE;
         end
         draft(id, 1'b0);
         draft(8'(sz), 1'b0);
         draft(flag, 1'b0);
         left = left - 1;
         if (id == rdbd_pkg::ID_END_REC) begin
            draft_words(left);
            left = 0;
         end else if (flag != rdbd_pkg::FLAG_OK) begin
            left = 0;
         end else if (sz <= left) begin
            draft_words(sz);
            left = left - sz;
         end else begin
            draft_words(left);
            next_carry = sz - left;
            left = 0;
         end
      end
      if (draft_q.size() > 150 || $urandom_range(0, 15) == 0) begin
         keep = $urandom_range(1, (draft_q.size() > 150 ? 150 : draft_q.size()) - 1);
         commit(keep);
         items_made += keep;
      end else begin
         items_made += draft_q.size();
         commit(draft_q.size());
         gen_carry = next_carry;
         // stray bytes between blocks
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 3)) draft(8'($urandom_range(0, 255)), 1'b0);
            commit(draft_q.size());
         end
      end
   endtask

   task automatic fill(input int budget, input logic with_drain);
      int goal;
      logic drain_pending;
      goal = items_made + budget;
      drain_pending = with_drain;
      while (items_made < goal) begin
         // pause the sender here until every result so far has come back
         if (drain_pending && items_made >= goal - budget / 2) begin
            drain_next = 1'b1;
            drain_pending = 1'b0;
         end
         random_block();
      end
   endtask

   task automatic write_save(input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_save_words <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      do @(posedge clock); while (bytes_taken != bytes_queued || results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic save, input logic idle_on, input int budget,
                            input logic with_drain);
      write_save(save);
      @(negedge clock);
      throttle = idle_on;
      fill(budget, with_drain);
      settle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_save(1'b1);
      @(negedge clock);
      throttle = 1'b1;

      // stray byte outside any block: dropped
      draft(8'hFF, 1'b0);
      // empty continuation, then nothing left after the header
      draft_header(8'd2, 8'h00);
      // new group whose size runs past the block: zero-size run, remainder 2
      draft_header(8'd3, rdbd_pkg::TYPE_NO_CONT);
      draft(8'hFF, 1'b0);
      draft(8'd2, 1'b0);
      draft(rdbd_pkg::FLAG_OK, 1'b0);
      // length wraps to 255, carried words first, then abandoned by a restart
      draft_header(8'd1, 8'hFC);
      draft(8'hFF, 1'b0);
      draft(8'h00, 1'b0);
      draft(8'h80, 1'b0);
      items_made += draft_q.size() - 1;
      commit(draft_q.size());
      gen_carry = 2;

      hold_req = 1'b1;
      fill(300, 1'b0);
      settle();
      run_phase(1'b0, 1'b1, 150, 1'b0);
      run_phase(1'b1, 1'b0, 150, 1'b0);
      run_phase(1'b0, 1'b1, 150, 1'b1);
      run_phase(1'b1, 1'b1, 200, 1'b1);

      if (fail_count == 0 && deframed_q.size() == 0)
         $display("recorder_data_block_deframer verification clean");
      else
         $display("recorder_data_block_deframer verification failed");
      $finish;
   end

endmodule

[sim.f]
rtl/core/rdbd_pkg.sv
rtl/core/rdbd_step.sv
rtl/core/rdbd_rsp_fifo.sv
rtl/core/recorder_data_block_deframer.sv
sim/testbench.sv
